// File: rtl/bfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bfs_pkg: shared types and constants of the 3x3 box filter
// Frame limits, field widths, divide-by-nine constants, queue entry format.
// ---------------------------------------------------------------------------
package bfs_pkg;

    // Frame and pixel limits
    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 4096;
    localparam int PIXEL_BITS   = 8;

    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT);

    // Configuration register widths and codes
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Window sum of nine pixels and its division by nine as a reciprocal multiply
    localparam int SUM_W        = PIXEL_BITS + 4;
    localparam int DIV_SHIFT    = SUM_W + 4;
    localparam int DIV9_RECIP   = ((1 << DIV_SHIFT) + 8) / 9;
    localparam int RECIP_W      = DIV_SHIFT - 3;
    localparam int PROD_W       = SUM_W + RECIP_W;

    localparam int TOTAL_W      = 32;

    // Result queue
    localparam int FIFO_DEPTH   = 8;
    localparam int PTR_W        = $clog2(FIFO_DEPTH);
    localparam int CNT_W        = $clog2(FIFO_DEPTH + 1);

    // Position of the filtered pixel that a window belongs to
    typedef struct packed {
        logic             interior;
        logic             end_frame;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_pos;

    // One queue entry: an optional filtered pixel and an optional statistics word
    typedef struct packed {
        logic                  has_pix;
        logic                  has_stat;
        logic [ROW_W-1:0]      row;
        logic [COL_W-1:0]      col;
        logic [PIXEL_BITS-1:0] val;
        logic [TOTAL_W-1:0]    total;
        logic [PIXEL_BITS-1:0] minimum;
    } t_entry;

endpackage
`default_nettype wire

// File: rtl/bfs_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bfs_if: handshake channels of the 3x3 box filter
// Pixel input, result output and configuration write channels.
// ---------------------------------------------------------------------------
interface bfs_pix_if import bfs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface bfs_res_if import bfs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  result_kind;
    logic [ROW_W-1:0]      row_index;
    logic [COL_W-1:0]      column_index;
    logic [PIXEL_BITS-1:0] filtered_value;
    logic [TOTAL_W-1:0]    frame_total;
    logic [PIXEL_BITS-1:0] frame_minimum;
    logic                  last_of_run;

    modport source (output valid, output result_kind, output row_index,
                    output column_index, output filtered_value, output frame_total,
                    output frame_minimum, output last_of_run, input ready);
    modport sink   (input valid, input result_kind, input row_index,
                    input column_index, input filtered_value, input frame_total,
                    input frame_minimum, input last_of_run, output ready);
endinterface

interface bfs_cfg_if import bfs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/bfs_line_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bfs_line_mem: line stores, window and neighborhood sum
// Reads the two stored rows at the pixel's column, shifts the 3x3 window,
// writes the column back in the next cycle and registers the nine-pixel sum.
// ---------------------------------------------------------------------------
module bfs_line_mem import bfs_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic [COL_W-1:0]      i_addr,
    input  wire logic [PIXEL_BITS-1:0] i_pixel,
    input  wire t_pos                  i_pos,
    output logic                       o_valid,
    output logic [SUM_W-1:0]           o_sum,
    output t_pos                       o_pos
);

    logic [PIXEL_BITS-1:0] r_upper_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] r_mid_mem   [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] r_upper_rd;
    logic [PIXEL_BITS-1:0] r_mid_rd;
    logic [PIXEL_BITS-1:0] r_win [6];

    logic                  r_valid;
    logic [COL_W-1:0]      r_addr;
    logic [PIXEL_BITS-1:0] r_px;
    t_pos                  r_pos;

    logic                  r_out_valid;
    logic [SUM_W-1:0]      r_sum;
    t_pos                  r_out_pos;

    logic [SUM_W-1:0]      n_sum;

    // Upper row store: read at accept, write back the old middle row.
    // Consecutive pixels always sit in different columns, so a read never
    // meets a write to the same entry.
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_upper_rd <= r_upper_mem[i_addr];
        end
        if (r_valid) begin
            r_upper_mem[r_addr] <= r_mid_rd;
        end
    end

    // Middle row store: read at accept, write back the new pixel
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_mid_rd <= r_mid_mem[i_addr];
        end
        if (r_valid) begin
            r_mid_mem[r_addr] <= r_px;
        end
    end

    // Hold the accepted word while the stores answer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        if (i_valid) begin
            r_addr <= i_addr;
            r_px   <= i_pixel;
            r_pos  <= i_pos;
        end
    end

    // Add the three new pixels to the six window pixels
    always_comb begin
        n_sum = SUM_W'(r_upper_rd) + SUM_W'(r_mid_rd) + SUM_W'(r_px);
        for (int k = 0; k < 6; k++) begin
            n_sum = n_sum + SUM_W'(r_win[k]);
        end
    end

    // Shift the window by one column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (r_valid) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= r_upper_rd;
            r_win[4] <= r_mid_rd;
            r_win[5] <= r_px;
        end
    end

    // Register the sum for the divide stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_valid;
        end
        if (r_valid) begin
            r_sum     <= n_sum;
            r_out_pos <= r_pos;
        end
    end

    assign o_valid = r_out_valid;
    assign o_sum   = r_sum;
    assign o_pos   = r_out_pos;

endmodule
`default_nettype wire

// File: rtl/bfs_stats.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bfs_stats: divide by nine and frame statistics
// Multiplies the window sum by the reciprocal of nine, then updates the
// saturating frame total and minimum and queues interior and frame-end pixels.
// ---------------------------------------------------------------------------
module bfs_stats import bfs_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [SUM_W-1:0] i_sum,
    input  wire t_pos             i_pos,
    output logic                  o_push,
    output t_entry                o_entry
);

    logic [PROD_W-1:0]     n_prod;
    logic                  r_valid;
    logic [PIXEL_BITS-1:0] r_val;
    t_pos                  r_pos;

    logic [TOTAL_W-1:0]    r_total;
    logic [PIXEL_BITS-1:0] r_min;

    logic [TOTAL_W:0]      n_wide;
    logic [TOTAL_W-1:0]    n_total;
    logic [PIXEL_BITS-1:0] n_min;

    // Floor of sum / 9 by reciprocal multiply
    assign n_prod = PROD_W'(i_sum) * PROD_W'(DIV9_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        if (i_valid) begin
            r_val <= n_prod[DIV_SHIFT +: PIXEL_BITS];
            r_pos <= i_pos;
        end
    end

    // Fold the filtered value into the frame statistics
    always_comb begin
        n_wide  = {1'b0, r_total} + (TOTAL_W + 1)'(r_val);
        n_total = r_total;
        n_min   = r_min;
        if (r_pos.interior) begin
            n_total = n_wide[TOTAL_W] ? '1 : n_wide[TOTAL_W-1:0];
            n_min   = (r_val < r_min) ? r_val : r_min;
        end
    end

    // Clear the statistics after the last pixel of a frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_min   <= '1;
        end else if (r_valid) begin
            if (r_pos.end_frame) begin
                r_total <= '0;
                r_min   <= '1;
            end else begin
                r_total <= n_total;
                r_min   <= n_min;
            end
        end
    end

    assign o_push = r_valid && (r_pos.interior || r_pos.end_frame);

    always_comb begin
        o_entry          = '0;
        o_entry.has_pix  = r_pos.interior;
        o_entry.has_stat = r_pos.end_frame;
        o_entry.row      = r_pos.row;
        o_entry.col      = r_pos.col;
        o_entry.val      = r_val;
        o_entry.total    = n_total;
        o_entry.minimum  = n_min;
    end

endmodule
`default_nettype wire

// File: rtl/bfs_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bfs_out_fifo: result queue
// Holds entries of up to two results and sends them one word at a time,
// the filtered pixel before the statistics word.
// ---------------------------------------------------------------------------
module bfs_out_fifo import bfs_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire t_entry      i_entry,
    output logic [CNT_W-1:0] o_count,
    bfs_res_if.source        o_res
);

    t_entry           r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             r_sub;

    t_entry           head;
    logic             show_pix;
    logic             take;
    logic             pop;

    assign head     = r_mem[r_rd_ptr];
    assign show_pix = head.has_pix && !r_sub;
    assign take     = o_res.valid && o_res.ready;
    assign pop      = take && (!show_pix || !head.has_stat);

    // Store a new entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Advance pointers, count and the word select
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_sub    <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
                r_sub    <= 1'b0;
            end else if (take) begin
                r_sub    <= 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_count = r_count;

    // Drive the head word
    assign o_res.valid          = (r_count != '0);
    assign o_res.result_kind    = !show_pix;
    assign o_res.row_index      = show_pix ? head.row : '0;
    assign o_res.column_index   = show_pix ? head.col : '0;
    assign o_res.filtered_value = show_pix ? head.val : '0;
    assign o_res.frame_total    = show_pix ? '0 : head.total;
    assign o_res.frame_minimum  = show_pix ? '0 : head.minimum;
    assign o_res.last_of_run    = show_pix ? !head.has_stat : 1'b1;

endmodule
`default_nettype wire

// File: rtl/box_filter_3x3_with_frame_stats.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// box_filter_3x3_with_frame_stats: 3x3 mean filter with frame statistics
// Result path: line store read, sum register, divide register, result queue.
// Throughput: one pixel per cycle, set by the single read and write-back of
// each line store column, while the result queue has room for every word in
// flight; the last pixel of a frame also adds a statistics word to the output.
// Reset (synchronous, active low) clears the position counters, statistics and
// result queue and sets the frame to 1024 x 768; the line stores are not
// cleared.
// ---------------------------------------------------------------------------
module box_filter_3x3_with_frame_stats import bfs_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bfs_pix_if.sink   i_pix,
    bfs_cfg_if.sink   i_cfg,
    bfs_res_if.source o_res
);

    logic [WIDTH_REG_W-1:0]  r_width;
    logic [HEIGHT_REG_W-1:0] r_height;
    logic [COL_W-1:0]        r_col;
    logic [ROW_W-1:0]        r_row;
    logic [2:0]              r_flight;

    logic [WIDTH_REG_W-1:0]  w_eff;
    logic [HEIGHT_REG_W-1:0] h_eff;
    logic                    end_row;
    logic                    end_frame;
    logic                    accept;
    t_pos                    pos;
    logic [CNT_W-1:0]        fifo_count;
    logic [CNT_W:0]          pending;

    logic                    lm_valid;
    logic [SUM_W-1:0]        lm_sum;
    t_pos                    lm_pos;
    logic                    st_push;
    t_entry                  st_entry;

    // Configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_REG_W'(1024);
            r_height <= HEIGHT_REG_W'(768);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_IMAGE_WIDTH:  r_width  <= i_cfg.data[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: r_height <= i_cfg.data;
                default:          r_width  <= r_width;
            endcase
        end
    end

    // Clamp the frame size to the supported range
    always_comb begin
        if (r_width < WIDTH_REG_W'(3)) begin
            w_eff = WIDTH_REG_W'(3);
        end else if (r_width > WIDTH_REG_W'(MAX_WIDTH)) begin
            w_eff = WIDTH_REG_W'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height < HEIGHT_REG_W'(3)) begin
            h_eff = HEIGHT_REG_W'(3);
        end else if (r_height > HEIGHT_REG_W'(MAX_HEIGHT)) begin
            h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
    end

    assign end_row   = (WIDTH_REG_W'(r_col) + WIDTH_REG_W'(1)) >= w_eff;
    assign end_frame = end_row && ((HEIGHT_REG_W'(r_row) + HEIGHT_REG_W'(1)) >= h_eff);

    // Take a pixel only when the queue has room for every word in flight
    assign pending     = (CNT_W + 1)'(fifo_count) + (CNT_W + 1)'(r_flight[0])
                       + (CNT_W + 1)'(r_flight[1]) + (CNT_W + 1)'(r_flight[2]);
    assign i_pix.ready = (pending <= (CNT_W + 1)'(FIFO_DEPTH - 1));
    assign accept      = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flight <= '0;
        end else begin
            r_flight <= {r_flight[1:0], accept};
        end
    end

    // Advance the raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (end_frame) begin
                r_col <= '0;
                r_row <= '0;
            end else if (end_row) begin
                r_col <= '0;
                r_row <= r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // The window centered one row up and one column left
    always_comb begin
        pos           = '0;
        pos.interior  = (r_col >= COL_W'(2)) && (r_row >= ROW_W'(2));
        pos.end_frame = end_frame;
        pos.row       = r_row - ROW_W'(1);
        pos.col       = r_col - COL_W'(1);
    end

    bfs_line_mem u_line_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_addr  (r_col),
        .i_pixel (i_pix.pixel_in),
        .i_pos   (pos),
        .o_valid (lm_valid),
        .o_sum   (lm_sum),
        .o_pos   (lm_pos)
    );

    bfs_stats u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (lm_valid),
        .i_sum   (lm_sum),
        .i_pos   (lm_pos),
        .o_push  (st_push),
        .o_entry (st_entry)
    );

    bfs_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (st_push),
        .i_entry (st_entry),
        .o_count (fifo_count),
        .o_res   (o_res)
    );

endmodule
`default_nettype wire
